[sv/teeb_pkg.sv]
// teeb_pkg: shared widths and word types for the triangle edge element basis unit
// no dependencies; imported by teeb_div, tri_edge_element_basis and teeb_chk

package teeb_pkg;

  // number formats
  localparam int CW         = 32;                        // coordinate width
  localparam int FRAC_BITS  = 16;                        // coordinate fraction bits
  localparam int PT_FRAC    = 16;                        // reference point fraction bits
  localparam int NUM_SHIFT  = 2 * FRAC_BITS - PT_FRAC;   // numerator alignment to det
  localparam int CURL_SHIFT = 3 * FRAC_BITS;             // curl numerator 2 << this
  localparam int PW         = 51;                        // barycentric product width
  localparam int DW         = PW + NUM_SHIFT + 1;        // divider dividend / divisor width
  localparam int QW         = 32;                        // quotient / result width
  localparam int DETW       = 64;                        // jac_det port width

  // sideband that travels beside the divider lanes
  typedef struct packed {
    logic [DETW-1:0] jdet;
    logic            det_sat;
    logic            sing;
    logic [8:0]      neg;
  } side_t;

  // one finished result word
  typedef struct packed {
    logic [DETW-1:0]       jac_det;
    logic [5:0][QW-1:0]    vec;
    logic [2:0][QW-1:0]    curl;
    logic                  singular;
    logic                  saturated;
  } result_t;

endpackage

[sv/teeb_div.sv]
// teeb_div: pipelined restoring divider lane, an entry stage then one quotient bit per register stage
// depends on teeb_pkg (DW, QW)

module teeb_div (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [teeb_pkg::DW-1:0] num_i,
  input  logic [teeb_pkg::DW-1:0] den_i,
  output logic [teeb_pkg::QW-1:0] quo_o,
  output logic                    ovf_o
);
  import teeb_pkg::*;

  logic [DW-1:0] rem_q [0:QW-1];
  logic [QW-1:0] low_q [0:QW-1];
  logic [DW-1:0] den_q [0:QW-1];
  logic [QW-1:0] quo_q [0:QW];
  logic          ovf_q [0:QW];
  logic          ovf_d;

  // quotient would need more than QW bits
  assign ovf_d = {{QW{1'b0}}, num_i[DW-1:QW]} >= den_i;

  // entry stage: high part of the dividend is the first partial remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{QW{1'b0}}, num_i[DW-1:QW]};
      low_q[0] <= num_i[QW-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
    end
  end

  // one trial subtraction per stage
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_q[j], low_q[j][QW-1]};
      diff  = trial - {1'b0, den_q[j]};
      ge    = trial >= {1'b0, den_q[j]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1] <= {quo_q[j][QW-2:0], ge};
        ovf_q[j+1] <= ovf_q[j];
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          low_q[j+1] <= {low_q[j][QW-2:0], 1'b0};
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

[sv/tri_edge_element_basis.sv]
// tri_edge_element_basis: first-order edge element basis on a linear triangle
// depends on teeb_pkg and teeb_div
//
//   channel  handshake                  direction  word
//   in       in_valid_i / in_stall_o    in         three nodes, edge signs, xi, eta
//   out      out_valid_o / out_stall_i  out        jac_det, six vector parts, three curls, flags
//   cfg      cfg_valid_i / cfg_ready_o  in         edge_ops_enable
//
// one word accepted per cycle while in_stall_o is low; a result passes through five
// arithmetic stages, 33 divider stages (an entry stage, then one quotient bit each)
// and the output register. reset clears all valid bits and sets edge_ops_enable to one.
// a stalled output word is held; a skid register takes one more word and the whole
// pipeline then freezes, raising in_stall_o until the skid register drains.

module tri_edge_element_basis (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [teeb_pkg::CW-1:0]     node0_x_i,
  input  logic [teeb_pkg::CW-1:0]     node0_y_i,
  input  logic [teeb_pkg::CW-1:0]     node1_x_i,
  input  logic [teeb_pkg::CW-1:0]     node1_y_i,
  input  logic [teeb_pkg::CW-1:0]     node2_x_i,
  input  logic [teeb_pkg::CW-1:0]     node2_y_i,
  input  logic [2:0]                  edge_signs_i,
  input  logic [16:0]                 point_xi_i,
  input  logic [16:0]                 point_eta_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [teeb_pkg::DETW-1:0]   jac_det_o,
  output logic [teeb_pkg::QW-1:0]     edge0_vx_o,
  output logic [teeb_pkg::QW-1:0]     edge0_vy_o,
  output logic [teeb_pkg::QW-1:0]     edge1_vx_o,
  output logic [teeb_pkg::QW-1:0]     edge1_vy_o,
  output logic [teeb_pkg::QW-1:0]     edge2_vx_o,
  output logic [teeb_pkg::QW-1:0]     edge2_vy_o,
  output logic [teeb_pkg::QW-1:0]     curl_edge0_o,
  output logic [teeb_pkg::QW-1:0]     curl_edge1_o,
  output logic [teeb_pkg::QW-1:0]     curl_edge2_o,
  output logic                        singular_o,
  output logic                        saturated_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i
);
  import teeb_pkg::*;

  localparam int        DTW      = 2 * CW + 3;          // determinant width
  localparam int        PRW      = 2 * CW + 2;          // jacobian product width
  localparam logic [17:0] PT_ONE = 18'(1 << PT_FRAC);
  localparam logic [DW-1:0] CURL_NUM = DW'(1) << (CURL_SHIFT + 2);

  logic en;
  logic ops_en_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      ops_en_q <= cfg_data_i;
    end
  end

  // ---------------- stage 1: edge differences ----------------
  logic signed [CW:0] a_d, b_d, c_d, d_d, bd_d, ca_d;
  logic signed [CW:0] a_q, b_q, c_q, d_q, bd_q, ca_q;
  logic        [16:0] xi_q, eta_q;
  logic signed [17:0] z_d, z_q;
  logic        [2:0]  sg1_q, sg2_q, sg3_q;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;

  always_comb begin
    a_d  = {node0_x_i[CW-1], node0_x_i} - {node2_x_i[CW-1], node2_x_i};
    b_d  = {node0_y_i[CW-1], node0_y_i} - {node2_y_i[CW-1], node2_y_i};
    c_d  = {node1_x_i[CW-1], node1_x_i} - {node2_x_i[CW-1], node2_x_i};
    d_d  = {node1_y_i[CW-1], node1_y_i} - {node2_y_i[CW-1], node2_y_i};
    bd_d = {node0_y_i[CW-1], node0_y_i} - {node1_y_i[CW-1], node1_y_i};
    ca_d = {node1_x_i[CW-1], node1_x_i} - {node0_x_i[CW-1], node0_x_i};
    z_d  = PT_ONE - {1'b0, point_xi_i} - {1'b0, point_eta_i};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      d_q   <= d_d;
      bd_q  <= bd_d;
      ca_q  <= ca_d;
      xi_q  <= point_xi_i;
      eta_q <= point_eta_i;
      z_q   <= z_d;
      sg1_q <= edge_signs_i;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [PW-1:0]  xe, ee, ze, ae, be, ce, de, bde, cae;
  logic signed [PRW-1:0] adx, ddx, bdx, cdx;
  logic signed [PRW-1:0] ad_q, bc_q;
  logic signed [PW-1:0]  pr_d [0:11];
  logic signed [PW-1:0]  pr_q [0:11];

  always_comb begin
    xe  = {{(PW-17){1'b0}}, xi_q};
    ee  = {{(PW-17){1'b0}}, eta_q};
    ze  = {{(PW-18){z_q[17]}}, z_q};
    ae  = {{(PW-CW-1){a_q[CW]}}, a_q};
    be  = {{(PW-CW-1){b_q[CW]}}, b_q};
    ce  = {{(PW-CW-1){c_q[CW]}}, c_q};
    de  = {{(PW-CW-1){d_q[CW]}}, d_q};
    bde = {{(PW-CW-1){bd_q[CW]}}, bd_q};
    cae = {{(PW-CW-1){ca_q[CW]}}, ca_q};
    adx = {{(PRW-CW-1){a_q[CW]}}, a_q};
    ddx = {{(PRW-CW-1){d_q[CW]}}, d_q};
    bdx = {{(PRW-CW-1){b_q[CW]}}, b_q};
    cdx = {{(PRW-CW-1){c_q[CW]}}, c_q};
    pr_d[0]  = xe * be;
    pr_d[1]  = ee * de;
    pr_d[2]  = xe * ae;
    pr_d[3]  = ee * ce;
    pr_d[4]  = ee * bde;
    pr_d[5]  = ze * be;
    pr_d[6]  = ee * cae;
    pr_d[7]  = ze * ae;
    pr_d[8]  = ze * de;
    pr_d[9]  = xe * bde;
    pr_d[10] = ze * ce;
    pr_d[11] = xe * cae;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ad_q  <= adx * ddx;
      bc_q  <= bdx * cdx;
      pr_q  <= pr_d;
      sg2_q <= sg1_q;
    end
  end

  // ---------------- stage 3: determinant and numerators ----------------
  logic signed [DTW-1:0] det_q;
  logic signed [PW:0]    pe [0:11];
  logic signed [PW:0]    num_d [0:5];
  logic signed [PW:0]    num_q [0:5];

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      pe[k] = {pr_q[k][PW-1], pr_q[k]};
    end
    num_d[0] = -pe[0] - pe[1];
    num_d[1] = pe[2] + pe[3];
    num_d[2] = pe[4] + pe[5];
    num_d[3] = pe[6] - pe[7];
    num_d[4] = pe[8] - pe[9];
    num_d[5] = -pe[10] - pe[11];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= {ad_q[PRW-1], ad_q} - {bc_q[PRW-1], bc_q};
      num_q <= num_d;
      sg3_q <= sg2_q;
    end
  end

  // ---------------- stage 4: magnitudes, signs, det saturation ----------------
  logic [PW-1:0]    absn_d [0:5];
  logic [PW-1:0]    absn_q [0:5];
  logic [DTW-1:0]   absd_d, absd_q;
  logic [DETW-1:0]  jdet_d;
  logic             dsat_d;
  logic [8:0]       neg_d;
  side_t            side4_q, side5_q;

  always_comb begin
    logic [PW:0] mag;
    for (int k = 0; k < 6; k++) begin
      mag       = num_q[k][PW] ? -num_q[k] : num_q[k];
      absn_d[k] = mag[PW-1:0];
      neg_d[k]  = num_q[k][PW] ^ det_q[DTW-1] ^ sg3_q[k/2];
    end
    for (int k = 0; k < 3; k++) begin
      neg_d[6+k] = sg3_q[k] ^ det_q[DTW-1];
    end
    absd_d = det_q[DTW-1] ? -det_q : det_q;
    dsat_d = (det_q[DTW-1:DETW-1] != '0) && (det_q[DTW-1:DETW-1] != '1);
    if (!dsat_d) begin
      jdet_d = det_q[DETW-1:0];
    end else if (det_q[DTW-1]) begin
      jdet_d = {1'b1, {(DETW-1){1'b0}}};
    end else begin
      jdet_d = {1'b0, {(DETW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      absn_q          <= absn_d;
      absd_q          <= absd_d;
      side4_q.jdet    <= jdet_d;
      side4_q.det_sat <= dsat_d;
      side4_q.sing    <= (det_q == '0);
      side4_q.neg     <= neg_d;
    end
  end

  // ---------------- stage 5: rounded dividends and divisor ----------------
  logic [DW-1:0] dvd_q [0:8];
  logic [DW-1:0] dvs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        dvd_q[k] <= {absn_q[k], {(NUM_SHIFT+1){1'b0}}} + {{(DW-DTW){1'b0}}, absd_q};
      end
      for (int k = 0; k < 3; k++) begin
        dvd_q[6+k] <= CURL_NUM + {{(DW-DTW){1'b0}}, absd_q};
      end
      dvs_q   <= {absd_q, 1'b0};
      side5_q <= side4_q;
    end
  end

  // valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // ---------------- divider lanes with sideband delay ----------------
  logic [QW-1:0] quo [0:8];
  logic          ovf [0:8];
  side_t         sd_q [0:QW];
  logic          dv_q [0:QW];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    teeb_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dvd_q[k]),
      .den_i (dvs_q),
      .quo_o (quo[k]),
      .ovf_o (ovf[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= side5_q;
      for (int j = 1; j <= QW; j++) begin
        sd_q[j] <= sd_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= QW; j++) begin
        dv_q[j] <= 1'b0;
      end
    end else if (en) begin
      dv_q[0] <= v5_q;
      for (int j = 1; j <= QW; j++) begin
        dv_q[j] <= dv_q[j-1];
      end
    end
  end

  // ---------------- result assembly: clip, sign, zeroing ----------------
  result_t       res_d;
  logic [QW-1:0] lane_val [0:8];
  logic [8:0]    lane_sat;
  logic          live;

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    live = ops_en_q & ~sd_q[QW].sing;
    for (int k = 0; k < 9; k++) begin
      lim         = sd_q[QW].neg[k] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      lane_sat[k] = ovf[k] | (quo[k] > lim);
      mag         = lane_sat[k] ? lim : quo[k];
      lane_val[k] = sd_q[QW].neg[k] ? -mag : mag;
    end
    for (int k = 0; k < 6; k++) begin
      res_d.vec[k] = live ? lane_val[k] : '0;
    end
    for (int k = 0; k < 3; k++) begin
      res_d.curl[k] = live ? lane_val[6+k] : '0;
    end
    res_d.jac_det   = sd_q[QW].jdet;
    res_d.singular  = sd_q[QW].sing;
    res_d.saturated = sd_q[QW].det_sat | (live & (|lane_sat));
  end

  // ---------------- output register and skid register ----------------
  logic    ov_q, sv_q, xfer;
  result_t od_q, sk_q;

  assign en         = ~sv_q;
  assign in_stall_o = sv_q;
  assign xfer       = en & dv_q[QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (ov_q && out_stall_i) begin
      if (xfer) begin
        sv_q <= 1'b1;
      end
    end else if (sv_q) begin
      ov_q <= 1'b1;
      sv_q <= 1'b0;
    end else begin
      ov_q <= xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && out_stall_i) begin
      if (xfer) begin
        sk_q <= res_d;
      end
    end else if (sv_q) begin
      od_q <= sk_q;
    end else if (xfer) begin
      od_q <= res_d;
    end
  end

  // output ports
  assign out_valid_o  = ov_q;
  assign jac_det_o    = od_q.jac_det;
  assign edge0_vx_o   = od_q.vec[0];
  assign edge0_vy_o   = od_q.vec[1];
  assign edge1_vx_o   = od_q.vec[2];
  assign edge1_vy_o   = od_q.vec[3];
  assign edge2_vx_o   = od_q.vec[4];
  assign edge2_vy_o   = od_q.vec[5];
  assign curl_edge0_o = od_q.curl[0];
  assign curl_edge1_o = od_q.curl[1];
  assign curl_edge2_o = od_q.curl[2];
  assign singular_o   = od_q.singular;
  assign saturated_o  = od_q.saturated;

endmodule

[sv/teeb_chk.sv]
// teeb_chk: port-level checks for tri_edge_element_basis, attached by bind
// depends on teeb_pkg and the top level's port names

module teeb_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [teeb_pkg::DETW-1:0]   jac_det_o,
  input logic [teeb_pkg::QW-1:0]     edge0_vx_o,
  input logic [teeb_pkg::QW-1:0]     edge1_vy_o,
  input logic [teeb_pkg::QW-1:0]     edge2_vx_o,
  input logic [teeb_pkg::QW-1:0]     curl_edge0_o,
  input logic [teeb_pkg::QW-1:0]     curl_edge2_o,
  input logic                        singular_o,
  input logic                        saturated_o
);
  import teeb_pkg::*;

  // a stalled output word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(jac_det_o) && $stable(curl_edge0_o))
    else $error("stalled output word changed");

  // input backpressure only while a result is waiting
  a_backp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

  // singular triangle gives zero determinant and zero vectors
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> jac_det_o == '0 && edge0_vx_o == '0 && edge1_vy_o == '0
      && edge2_vx_o == '0 && curl_edge0_o == '0 && curl_edge2_o == '0)
    else $error("singular word with non-zero outputs");

  // nothing is clipped on a singular triangle
  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> !saturated_o)
    else $error("singular word flagged saturated");

endmodule

bind tri_edge_element_basis teeb_chk u_chk (.*);
